// File: hdl/bmhq_pkg.sv
// bmhq_pkg: shared types and codes for the binary min-heap priority queue.
// No dependencies; compile first.
`timescale 1ns / 1ps
`default_nettype none

package bmhq_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  // Operation codes of the mode field
  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_DN_LOAD,
    ST_DN_RD,
    ST_DN_CMP,
    ST_FINISH
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load_req;     // take the request transaction
    logic rd_parent;    // read the parent of the hole
    logic rd_children;  // read both children of the hole
    logic dn_load;      // capture root as result, last entry as mover
    logic wr_hold;      // write the moving entry into the hole, sift ends
    logic wr_up;        // move the parent down into the hole, hole climbs
    logic wr_dn;        // move the smaller child up into the hole, hole descends
    logic rsp_load;     // load the response register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic req_pop;       // request is a pop
    logic full;          // heap holds CAPACITY entries
    logic empty;         // heap holds no entry
    logic at_root;       // hole is at position one
    logic no_left;       // hole has no left child
    logic parent_gt;     // parent key strictly greater than moving key
    logic hold_gt_pick;  // moving key strictly greater than chosen child key
    logic rsp_busy;      // response register cannot take a new result
  } stat_t;

endpackage

`default_nettype wire

// File: hdl/bmhq_req_if.sv
// bmhq_req_if: request channel of the heap queue (valid/ready plus mode, key, tag).
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface bmhq_req_if #(
  parameter int unsigned KEY_BITS = 24,
  parameter int unsigned TAG_BITS = 8
);
  logic                valid;
  logic                ready;
  logic                mode;
  logic [KEY_BITS-1:0] key;
  logic [TAG_BITS-1:0] tag;

  modport source (output valid, output mode, output key, output tag, input ready);
  modport sink   (input valid, input mode, input key, input tag, output ready);
endinterface

`default_nettype wire

// File: hdl/bmhq_rsp_if.sv
// bmhq_rsp_if: response channel of the heap queue (valid/ready plus result fields).
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface bmhq_rsp_if #(
  parameter int unsigned KEY_BITS  = 24,
  parameter int unsigned TAG_BITS  = 8,
  parameter int unsigned FILL_BITS = 7
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  logic [KEY_BITS-1:0]  out_key;
  logic [TAG_BITS-1:0]  out_tag;
  logic [FILL_BITS-1:0] fill_level;

  modport source (output valid, output status, output out_key, output out_tag,
                  output fill_level, input ready);
  modport sink   (input valid, input status, input out_key, input out_tag,
                  input fill_level, output ready);
endinterface

`default_nettype wire

// File: hdl/bmhq_ctrl.sv
// bmhq_ctrl: state machine that sequences push sift-up and pop sift-down.
// Depends on bmhq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bmhq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  output logic            req_ready_o,
  input  bmhq_pkg::stat_t stat_i,
  output bmhq_pkg::cmd_t  cmd_o
);
  import bmhq_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          if (stat_i.req_pop) begin
            state_d = stat_i.empty ? ST_FINISH : ST_DN_LOAD;
          end else begin
            state_d = stat_i.full ? ST_FINISH : ST_UP_RD;
          end
        end
      end
      ST_UP_RD:   state_d = stat_i.at_root ? ST_FINISH : ST_UP_CMP;
      ST_UP_CMP:  state_d = stat_i.parent_gt ? ST_UP_RD : ST_FINISH;
      ST_DN_LOAD: state_d = ST_DN_RD;
      ST_DN_RD:   state_d = stat_i.no_left ? ST_FINISH : ST_DN_CMP;
      ST_DN_CMP:  state_d = stat_i.hold_gt_pick ? ST_DN_RD : ST_FINISH;
      ST_FINISH:  state_d = stat_i.rsp_busy ? ST_FINISH : ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        req_ready_o    = 1'b1;
        cmd_o.load_req = req_valid_i;
      end
      ST_UP_RD: begin
        if (stat_i.at_root) begin
          cmd_o.wr_hold = 1'b1;
        end else begin
          cmd_o.rd_parent = 1'b1;
        end
      end
      ST_UP_CMP: begin
        if (stat_i.parent_gt) begin
          cmd_o.wr_up = 1'b1;
        end else begin
          cmd_o.wr_hold = 1'b1;
        end
      end
      ST_DN_LOAD: cmd_o.dn_load = 1'b1;
      ST_DN_RD: begin
        if (stat_i.no_left) begin
          cmd_o.wr_hold = 1'b1;
        end else begin
          cmd_o.rd_children = 1'b1;
        end
      end
      ST_DN_CMP: begin
        if (stat_i.hold_gt_pick) begin
          cmd_o.wr_dn = 1'b1;
        end else begin
          cmd_o.wr_hold = 1'b1;
        end
      end
      ST_FINISH: cmd_o.rsp_load = !stat_i.rsp_busy;
      default: begin
        cmd_o       = '0;
        req_ready_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/bmhq_dp.sv
// bmhq_dp: heap storage (two-read, one-write memory), hole pointer, fill count,
// moving entry and response register. Depends on bmhq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bmhq_dp #(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned KEY_BITS = 24,
  parameter int unsigned TAG_BITS = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  bmhq_pkg::cmd_t                 cmd_i,
  output bmhq_pkg::stat_t                stat_o,
  input  logic                           req_mode_i,
  input  logic [KEY_BITS-1:0]            req_key_i,
  input  logic [TAG_BITS-1:0]            req_tag_i,
  input  logic                           rsp_ready_i,
  output logic                           rsp_valid_o,
  output logic [1:0]                     rsp_status_o,
  output logic [KEY_BITS-1:0]            rsp_key_o,
  output logic [TAG_BITS-1:0]            rsp_tag_o,
  output logic [$clog2(CAPACITY+1)-1:0]  rsp_fill_o
);
  import bmhq_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = $clog2(CAPACITY);

  // Heap store, position p lives at address p-1
  logic [KEY_BITS-1:0] key_mem [CAPACITY];
  logic [TAG_BITS-1:0] tag_mem [CAPACITY];

  logic [KEY_BITS-1:0] a_key_q, b_key_q, hold_key_q, res_key_q, rsp_key_q;
  logic [TAG_BITS-1:0] a_tag_q, b_tag_q, hold_tag_q, res_tag_q, rsp_tag_q;
  status_e             res_status_q, res_status_d;
  logic [1:0]          rsp_status_q;
  logic [CW-1:0]       rsp_fill_q;
  logic [CW-1:0]       count_q, count_d, pos_q, pos_d;
  logic                rsp_valid_q, rsp_valid_d;

  logic                req_pop, full, empty, no_right, pick_b;
  logic [CW-1:0]       parent, parent_m1, count_m1;
  logic [CW:0]         left, left_m1, right;
  logic [KEY_BITS-1:0] pick_key;
  logic [TAG_BITS-1:0] pick_tag;
  logic                rd_en, wr_en;
  logic [AW-1:0]       rd_a_addr, rd_b_addr, wr_addr, pos_m1;
  logic [KEY_BITS-1:0] wr_key;
  logic [TAG_BITS-1:0] wr_tag;
  logic [CW-1:0]       pos_dec;

  assign req_pop   = (req_mode_i == MODE_POP);
  assign full      = (count_q == CW'(CAPACITY));
  assign empty     = (count_q == '0);
  assign parent    = pos_q >> 1;
  assign parent_m1 = parent - 1'b1;
  assign count_m1  = count_q - 1'b1;
  assign left      = {pos_q, 1'b0};
  assign left_m1   = left - 1'b1;
  assign right     = left + 1'b1;
  assign no_right  = (right > {1'b0, count_q});
  assign pick_b    = !no_right && (b_key_q < a_key_q);
  assign pick_key  = pick_b ? b_key_q : a_key_q;
  assign pick_tag  = pick_b ? b_tag_q : a_tag_q;
  assign pos_dec   = pos_q - 1'b1;
  assign pos_m1    = pos_dec[AW-1:0];

  always_comb begin
    stat_o              = '0;
    stat_o.req_pop      = req_pop;
    stat_o.full         = full;
    stat_o.empty        = empty;
    stat_o.at_root      = (pos_q == CW'(1));
    stat_o.no_left      = (left > {1'b0, count_q});
    stat_o.parent_gt    = (a_key_q > hold_key_q);
    stat_o.hold_gt_pick = (hold_key_q > pick_key);
    stat_o.rsp_busy     = rsp_valid_q && !rsp_ready_i;
  end

  // Read ports: root and last on a pop, parent on sift-up, both children on sift-down
  always_comb begin
    rd_en     = (cmd_i.load_req && req_pop) || cmd_i.rd_parent || cmd_i.rd_children;
    rd_a_addr = '0;
    rd_b_addr = count_m1[AW-1:0];
    if (cmd_i.rd_parent) begin
      rd_a_addr = parent_m1[AW-1:0];
    end else if (cmd_i.rd_children) begin
      rd_a_addr = left_m1[AW-1:0];
      rd_b_addr = left[AW-1:0];
    end
  end

  // Write port: always into the hole
  always_comb begin
    wr_en   = cmd_i.wr_hold || cmd_i.wr_up || cmd_i.wr_dn;
    wr_addr = pos_m1;
    wr_key  = hold_key_q;
    wr_tag  = hold_tag_q;
    if (cmd_i.wr_up) begin
      wr_key = a_key_q;
      wr_tag = a_tag_q;
    end else if (cmd_i.wr_dn) begin
      wr_key = pick_key;
      wr_tag = pick_tag;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
      tag_mem[wr_addr] <= wr_tag;
    end
    if (rd_en) begin
      a_key_q <= key_mem[rd_a_addr];
      a_tag_q <= tag_mem[rd_a_addr];
      b_key_q <= key_mem[rd_b_addr];
      b_tag_q <= tag_mem[rd_b_addr];
    end
  end

  always_comb begin
    res_status_d = STATUS_OK;
    if (req_pop && empty) begin
      res_status_d = STATUS_EMPTY;
    end else if (!req_pop && full) begin
      res_status_d = STATUS_FULL;
    end
  end

  // Moving entry and pending result
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      hold_key_q   <= req_key_i;
      hold_tag_q   <= req_tag_i;
      res_key_q    <= '0;
      res_tag_q    <= '0;
      res_status_q <= res_status_d;
    end else if (cmd_i.dn_load) begin
      hold_key_q <= b_key_q;
      hold_tag_q <= b_tag_q;
      res_key_q  <= a_key_q;
      res_tag_q  <= a_tag_q;
    end
    if (cmd_i.rsp_load) begin
      rsp_status_q <= res_status_q;
      rsp_key_q    <= res_key_q;
      rsp_tag_q    <= res_tag_q;
      rsp_fill_q   <= count_q;
    end
  end

  always_comb begin
    count_d     = count_q;
    pos_d       = pos_q;
    rsp_valid_d = rsp_valid_q;
    if (cmd_i.load_req && !req_pop && !full) begin
      count_d = count_q + 1'b1;
      pos_d   = count_q + 1'b1;
    end
    if (cmd_i.dn_load) begin
      count_d = count_m1;
      pos_d   = CW'(1);
    end
    if (cmd_i.wr_up) begin
      pos_d = parent;
    end
    if (cmd_i.wr_dn) begin
      pos_d = pick_b ? right[CW-1:0] : left[CW-1:0];
    end
    if (cmd_i.rsp_load) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      pos_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      pos_q       <= pos_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  assign rsp_valid_o  = rsp_valid_q;
  assign rsp_status_o = rsp_status_q;
  assign rsp_key_o    = rsp_key_q;
  assign rsp_tag_o    = rsp_tag_q;
  assign rsp_fill_o   = rsp_fill_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("fill count beyond capacity");

  a_write_in_heap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (pos_q != '0) && ((pos_q <= count_q) || (pos_q == CW'(1))))
    else $error("heap write outside occupied positions");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_req && !req_pop && !full |=> count_q == CW'($past(count_q) + 1'b1))
    else $error("accepted push did not grow the heap");

  a_pop_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.dn_load |=> count_q == CW'($past(count_q) - 1'b1))
    else $error("pop did not shrink the heap");

endmodule

`default_nettype wire

// File: hdl/binary_min_heap_queue.sv
// Binary min-heap priority queue: one request transaction (push or pop) in, one response out;
// sift-up/down walk one heap level per read and compare step (two registered reads, one write port).
// A push climbs and a pop descends up to log2(CAPACITY) levels; refused ops skip the sift.
// The next request is taken from the cycle after the response loads; a stalled response holds
// the FSM.
// Reset (async, active low) empties the heap; the store itself is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module binary_min_heap_queue #(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned KEY_BITS = 24,
  parameter int unsigned TAG_BITS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bmhq_req_if.sink   req_i,
  bmhq_rsp_if.source rsp_o
);
  import bmhq_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  // Command and status groups between controller and datapath
  cmd_t  cmd;
  stat_t stat;

  logic                req_ready;
  logic                rsp_valid;
  logic [1:0]          rsp_status;
  logic [KEY_BITS-1:0] rsp_key;
  logic [TAG_BITS-1:0] rsp_tag;
  logic [CW-1:0]       rsp_fill;

  // Controller: accepts a transaction only in idle, then steps the sift loop
  // one level at a time (read, then compare and write) until the hole settles.
  bmhq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Datapath: heap memory, hole pointer, fill count and the response register.
  // The response register holds a finished result until the sink takes it,
  // while the controller returns to idle and accepts the next request.
  bmhq_dp #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS),
    .TAG_BITS (TAG_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .req_mode_i   (req_i.mode),
    .req_key_i    (req_i.key),
    .req_tag_i    (req_i.tag),
    .rsp_ready_i  (rsp_o.ready),
    .rsp_valid_o  (rsp_valid),
    .rsp_status_o (rsp_status),
    .rsp_key_o    (rsp_key),
    .rsp_tag_o    (rsp_tag),
    .rsp_fill_o   (rsp_fill)
  );

  // Drive the channel ports
  assign req_i.ready      = req_ready;
  assign rsp_o.valid      = rsp_valid;
  assign rsp_o.status     = rsp_status;
  assign rsp_o.out_key    = rsp_key;
  assign rsp_o.out_tag    = rsp_tag;
  assign rsp_o.fill_level = rsp_fill;

endmodule

`default_nettype wire

// File: tb/testbench.sv
// testbench: self-checking bench for binary_min_heap_queue, which drives random push and pop
// transactions through the request and response interfaces and checks each response.
// Depends on bmhq_pkg, bmhq_req_if, bmhq_rsp_if and binary_min_heap_queue.
`timescale 1ns / 1ps

module testbench;
  import bmhq_pkg::*;

  localparam int unsigned CAPACITY    = 64;
  localparam int unsigned KEY_BITS    = 24;
  localparam int unsigned TAG_BITS    = 8;
  localparam int unsigned FILL_BITS   = 7;
  localparam int unsigned PHASE_ITEMS = 375;  // four phases, about 1500 requests
  localparam int unsigned DRAIN_WAIT  = 40;   // well beyond the longest operation
  localparam int          CYCLE_LIMIT = 400000;

  // One predicted response transaction
  typedef struct {
    status_e              status;
    logic [KEY_BITS-1:0]  out_key;
    logic [TAG_BITS-1:0]  out_tag;
    logic [FILL_BITS-1:0] fill_level;
  } heap_result_t;

  // Mirror of the heap: predicts each response and checks the block against it
  class heap_tracker;
    logic [KEY_BITS-1:0] slot_key[1:CAPACITY];
    logic [TAG_BITS-1:0] slot_tag[1:CAPACITY];
    int unsigned         held;
    heap_result_t        awaited[$];
    int unsigned         failures;

    function new();
      held     = 0;
      failures = 0;
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    function void swap_slots(int unsigned a, int unsigned b);
      logic [KEY_BITS-1:0] k;
      logic [TAG_BITS-1:0] t;
      k           = slot_key[a];
      t           = slot_tag[a];
      slot_key[a] = slot_key[b];
      slot_tag[a] = slot_tag[b];
      slot_key[b] = k;
      slot_tag[b] = t;
    endfunction

    // Apply one accepted request to the mirror and queue its response
    function void take_request(logic op, logic [KEY_BITS-1:0] key, logic [TAG_BITS-1:0] tag);
      heap_result_t res;
      int unsigned  pos;
      int unsigned  pick;
      res.status  = STATUS_OK;
      res.out_key = '0;
      res.out_tag = '0;
      if (op == MODE_PUSH) begin
        if (held >= CAPACITY) begin
          res.status = STATUS_FULL;
        end else begin
          held++;
          slot_key[held] = key;
          slot_tag[held] = tag;
          // climb while the parent is strictly larger; equal keys stay put
          pos = held;
          while (pos > 1 && slot_key[pos / 2] > slot_key[pos]) begin
            swap_slots(pos / 2, pos);
            pos = pos / 2;
          end
        end
      end else begin
        if (held == 0) begin
          res.status = STATUS_EMPTY;
        end else begin
          res.out_key = slot_key[1];
          res.out_tag = slot_tag[1];
          slot_key[1] = slot_key[held];
          slot_tag[1] = slot_tag[held];
          held--;
          // descend; a tie between children goes left
          pos = 1;
          while (2 * pos <= held) begin
            pick = 2 * pos;
            if (pick + 1 <= held && slot_key[pick] > slot_key[pick + 1]) pick = pick + 1;
            if (slot_key[pos] <= slot_key[pick]) break;
            swap_slots(pos, pick);
            pos = pick;
          end
        end
      end
      res.fill_level = FILL_BITS'(held);
      awaited.push_back(res);
    endfunction

    // Compare one accepted response with the oldest prediction
    function void check_response(logic [1:0] status, logic [KEY_BITS-1:0] out_key,
                                 logic [TAG_BITS-1:0] out_tag, logic [FILL_BITS-1:0] fill);
      heap_result_t res;
      if (awaited.size() == 0) begin
        $error("response with no request pending: status %0d key %0h tag %0h fill %0d",
               status, out_key, out_tag, fill);
        failures++;
        return;
      end
      res = awaited.pop_front();
      if (status !== res.status) begin
        $error("status: expected %0d, actual %0d", res.status, status);
        failures++;
      end
      if (out_key !== res.out_key) begin
        $error("out_key: expected %0h, actual %0h", res.out_key, out_key);
        failures++;
      end
      if (out_tag !== res.out_tag) begin
        $error("out_tag: expected %0h, actual %0h", res.out_tag, out_tag);
        failures++;
      end
      if (fill !== res.fill_level) begin
        $error("fill_level: expected %0d, actual %0d", res.fill_level, fill);
        failures++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  int          cycle_count = 0;
  int unsigned send_idle_pct;   // chance per cycle that the sender holds off
  int unsigned recv_stall_pct;  // chance per cycle that the receiver stalls
  heap_tracker tracker;

  bmhq_req_if #(.KEY_BITS(KEY_BITS), .TAG_BITS(TAG_BITS)) req_bus ();
  bmhq_rsp_if #(.KEY_BITS(KEY_BITS), .TAG_BITS(TAG_BITS), .FILL_BITS(FILL_BITS)) rsp_bus ();

  binary_min_heap_queue #(
    .CAPACITY(CAPACITY),
    .KEY_BITS(KEY_BITS),
    .TAG_BITS(TAG_BITS)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_bus),
    .rsp_o (rsp_bus)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Key mix: many ties among tiny keys, both extremes, and the full range
  function automatic logic [KEY_BITS-1:0] pick_key();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2, 3:    return KEY_BITS'($urandom_range(7));
      default: return KEY_BITS'($urandom());
    endcase
  endfunction

  // Present one request transaction, idling first at random, and record it once accepted.
  // Keep valid high across back-to-back requests; drop it only for an idle gap.
  task automatic send_op(input logic op, input logic [KEY_BITS-1:0] key,
                         input logic [TAG_BITS-1:0] tag);
    if ($urandom_range(99) < send_idle_pct) begin
      req_bus.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    req_bus.valid <= 1'b1;
    req_bus.mode  <= op;
    req_bus.key   <= key;
    req_bus.tag   <= tag;
    // sample ready as it stood at the edge
    do @(posedge clk_i); while (!req_bus.ready);
    tracker.take_request(op, key, tag);
  endtask

  // Response side: check every accepted transaction, then choose ready for the next edge
  always @(posedge clk_i) begin
    cycle_count = cycle_count + 1;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      tracker.check_response(rsp_bus.status, rsp_bus.out_key, rsp_bus.out_tag,
                             rsp_bus.fill_level);
    end
    rsp_bus.ready <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: a hung handshake or a missing response ends the run here
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    int unsigned sent;
    int unsigned burst_len;
    int unsigned push_pct;
    int unsigned phase;
    bit          first_burst;
    logic        op;

    tracker        = new();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_ni        <= 1'b0;
    req_bus.valid <= 1'b0;
    req_bus.mode  <= MODE_PUSH;
    req_bus.key   <= '0;
    req_bus.tag   <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: pop on empty, key and tag extremes, equal keys, drain to empty,
    // pop of a lone entry
    send_op(MODE_POP,  '0,           '0);
    send_op(MODE_PUSH, '1,           '1);
    send_op(MODE_PUSH, '0,           '0);
    send_op(MODE_PUSH, 24'd5,        8'h11);
    send_op(MODE_PUSH, 24'd5,        8'h22);
    send_op(MODE_PUSH, 24'd5,        8'h33);
    send_op(MODE_PUSH, 24'h800000,   8'hAA);
    send_op(MODE_PUSH, 24'h7FFFFF,   8'h55);
    send_op(MODE_PUSH, 24'd5,        8'h44);
    repeat (8) send_op(MODE_POP, pick_key(), 8'($urandom_range(255)));
    send_op(MODE_POP,  '1,           '1);
    send_op(MODE_PUSH, 24'hABCDEF,   8'h5A);
    send_op(MODE_POP,  '0,           '0);
    send_op(MODE_POP,  '0,           '0);

    // Random: four phases of pacing; bursts lean toward filling, draining or mixing
    // so that both the full and the empty refusal come up often
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 87; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 87; end
        default: begin send_idle_pct = 7;  recv_stall_pct = 7;  end
      endcase
      sent        = 0;
      first_burst = 1'b1;
      while (sent < PHASE_ITEMS) begin
        // open each phase with a long fill burst that overruns the capacity
        if (first_burst) begin
          burst_len = 110;
          push_pct  = 85;
        end else begin
          burst_len = $urandom_range(20, 150);
          case ($urandom_range(2))
            0:       push_pct = 85;
            1:       push_pct = 15;
            default: push_pct = 50;
          endcase
        end
        first_burst = 1'b0;
        for (int i = 0; i < burst_len && sent < PHASE_ITEMS; i++) begin
          op = ($urandom_range(99) < push_pct) ? MODE_PUSH : MODE_POP;
          send_op(op, pick_key(), 8'($urandom_range(255)));
          sent++;
        end
      end
    end

    // Release the request side, let every response drain, then allow stray output
    @(posedge clk_i);
    req_bus.valid  <= 1'b0;
    recv_stall_pct  = 0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (tracker.failures == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
